>>> rtl/rxsort_pkg.sv
// Shared constants and the record type for the exchange sort block.
// No dependencies; every other file but rxsort_ram imports this package.
`default_nettype none

package rxsort_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 16;
  localparam int TAG_W       = 16;
  localparam int REC_W       = KEY_W + TAG_W;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } rec_t;

endpackage

`default_nettype wire

>>> rtl/rxsort_if.sv
// Valid/ready channel interfaces for the record input and sorted output.
// Depends on rxsort_pkg for the field widths.
`default_nettype none

interface rxsort_in_if;
  import rxsort_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sort_key;
  logic [TAG_W-1:0]        record_tag;
  logic                    batch_end;

  modport source (output valid, output sort_key, output record_tag, output batch_end,
                  input ready);
  modport sink   (input valid, input sort_key, input record_tag, input batch_end,
                  output ready);
endinterface

interface rxsort_out_if;
  import rxsort_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0]        sorted_tag;
  logic                    final_result;
  logic                    overflowed;

  modport source (output valid, output sorted_key, output sorted_tag, output final_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_key, input sorted_tag, input final_result,
                  input overflowed, output ready);
endinterface

`default_nettype wire

>>> rtl/record_exchange_sort_by_key.sv
// Record exchange sort by key: top level.
// Depends on rxsort_pkg, rxsort_if (channel interfaces) and rxsort_ram.
//
// Records (signed key, tag) are taken one per cycle into a 64-entry RAM until the
// record marked batch_end arrives; records beyond 64 are dropped and every result
// of that batch carries overflowed. On the close the block runs an exchange sort
// in place: entry i is held in a register and compared against entries i+1..n-1
// streamed from the single RAM read port at one compare per cycle, swapping on a
// strictly greater key, so equal keys keep the order that this scheme gives. The
// results then leave at one per cycle while the sink is ready, final_result
// marking the last. Input is refused from the close until the last result is in
// the output register; a new batch may load while that result waits to be taken.
`default_nettype none

module record_exchange_sort_by_key (
  input  logic            clk,
  input  logic            rst,
  rxsort_in_if.sink       rec_in,
  rxsort_out_if.source    rec_out
);

  import rxsort_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SORT_I,
    S_SORT_I_WAIT,
    S_SORT_J,
    S_SORT_WB,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] fill_count;
  logic             drop_flag;
  logic [IDX_W-1:0] idx_i;
  logic [IDX_W-1:0] idx_j;
  logic [IDX_W-1:0] idx_k;
  rec_t             cur;

  logic             out_valid;
  rec_t             out_rec;
  logic             out_final;
  logic             out_ovf;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  rec_t             rd_rec;

  logic             in_take;
  logic             room;
  logic [IDX_W-1:0] last_idx;
  logic             swap;
  logic             out_free;

  rxsort_ram #(
    .DEPTH (MAX_RECORDS),
    .WIDTH (REC_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec   = rec_t'(ram_rdata);
  assign rec_in.ready = (state == S_LOAD);
  assign in_take  = rec_in.valid && rec_in.ready;
  assign room     = (fill_count != CNT_W'(MAX_RECORDS));
  assign last_idx = IDX_W'(fill_count - CNT_W'(1));
  assign swap     = ($signed(cur.key) > $signed(rd_rec.key));
  assign out_free = !out_valid || rec_out.ready;

  assign rec_out.valid        = out_valid;
  assign rec_out.sorted_key   = out_rec.key;
  assign rec_out.sorted_tag   = out_rec.tag;
  assign rec_out.final_result = out_final;
  assign rec_out.overflowed   = out_ovf;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_j;
    ram_wdata = cur;
    ram_re    = 1'b0;
    ram_raddr = idx_i;
    unique case (state)
      S_LOAD: begin
        if (in_take && room) begin
          ram_we    = 1'b1;
          ram_waddr = fill_count[IDX_W-1:0];
          ram_wdata = '{key: rec_in.sort_key, tag: rec_in.record_tag};
        end
      end
      S_SORT_I: begin
        ram_re    = 1'b1;
        ram_raddr = idx_i;
      end
      S_SORT_I_WAIT: begin
        ram_re    = 1'b1;
        ram_raddr = idx_i + IDX_W'(1);
      end
      S_SORT_J: begin
        // write back the displaced entry while fetching the next one
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = idx_j;
          ram_wdata = cur;
        end
        if (idx_j != last_idx) begin
          ram_re    = 1'b1;
          ram_raddr = idx_j + IDX_W'(1);
        end
      end
      S_SORT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_i;
        ram_wdata = cur;
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_k;
      end
      S_EMIT_WAIT: begin
        if (out_free && idx_k != last_idx) begin
          ram_re    = 1'b1;
          ram_raddr = idx_k + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      fill_count <= '0;
      drop_flag  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop the held result once taken; the emit state reloads it itself
      if (out_valid && rec_out.ready && state != S_EMIT_WAIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_take) begin
            if (room) begin
              fill_count <= fill_count + CNT_W'(1);
            end else begin
              drop_flag <= 1'b1;
            end
            if (rec_in.batch_end) begin
              idx_i <= '0;
              state <= S_SORT_I;
            end
          end
        end
        S_SORT_I: begin
          // a single record needs no sort; the read just issued is entry 0
          if (fill_count == CNT_W'(1)) begin
            idx_k <= '0;
            state <= S_EMIT_WAIT;
          end else begin
            state <= S_SORT_I_WAIT;
          end
        end
        S_SORT_I_WAIT: begin
          cur   <= rd_rec;
          idx_j <= idx_i + IDX_W'(1);
          state <= S_SORT_J;
        end
        S_SORT_J: begin
          if (swap) begin
            cur <= rd_rec;
          end
          if (idx_j == last_idx) begin
            state <= S_SORT_WB;
          end else begin
            idx_j <= idx_j + IDX_W'(1);
          end
        end
        S_SORT_WB: begin
          if (CNT_W'(idx_i) + CNT_W'(2) == fill_count) begin
            idx_k <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx_i <= idx_i + IDX_W'(1);
            state <= S_SORT_I;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_rec   <= rd_rec;
            out_final <= (idx_k == last_idx);
            out_ovf   <= drop_flag;
            if (idx_k == last_idx) begin
              fill_count <= '0;
              drop_flag  <= 1'b0;
              state      <= S_LOAD;
            end else begin
              idx_k <= idx_k + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_RECORDS))
    else $error("fill count beyond capacity");

  a_sort_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT_J) |-> (idx_j > idx_i) && (CNT_W'(idx_j) < fill_count))
    else $error("compare index outside the stored records");

  a_emit_final: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WAIT && out_free && idx_k == last_idx) |=>
      (state == S_LOAD) && out_valid && out_final && (fill_count == '0))
    else $error("batch did not close after the final result");
`endif

endmodule

`default_nettype wire

>>> rtl/rxsort_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
`default_nettype none

module rxsort_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for record_exchange_sort_by_key: drives batches of records,
// predicts the sorted output in a scoreboard class and checks every result transfer.
// Depends on rxsort_pkg, the rxsort_if channel interfaces and the block's RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rxsort_pkg::*;

  localparam int ITEMS        = 260;
  localparam int CALM_ITEMS   = 40;
  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum int {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_EDGES} key_spread_e;

  typedef struct {
    rec_t rec;
    logic last;
    logic ovf;
  } sorted_exp_t;

  class sort_scoreboard;
    rec_t          store [MAX_RECORDS];
    int unsigned   fill;
    bit            dropped;
    sorted_exp_t   awaited [$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   batches;
    int unsigned   overflow_batches;

    function new();
      fill             = 0;
      dropped          = 1'b0;
      mismatches       = 0;
      checked          = 0;
      batches          = 0;
      overflow_batches = 0;
    endfunction

    // Store the record, and on the close sort the batch and queue its results.
    function void note_record(rec_t r, logic closes);
      rec_t        tmp;
      sorted_exp_t e;
      if (fill < MAX_RECORDS) begin
        store[fill] = r;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!closes) return;
      for (int i = 0; i < fill; i++) begin
        for (int j = i; j < fill; j++) begin
          if (store[i].key > store[j].key) begin
            tmp      = store[i];
            store[i] = store[j];
            store[j] = tmp;
          end
        end
      end
      for (int k = 0; k < fill; k++) begin
        e.rec  = store[k];
        e.last = (k + 1 == fill);
        e.ovf  = dropped;
        awaited.push_back(e);
      end
      batches++;
      if (dropped) overflow_batches++;
      fill    = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(rec_t got, logic last, logic ovf);
      sorted_exp_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result key %0d tag %h", $time, got.key, got.tag);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (got.key !== e.rec.key) begin
        $display("%0t: sorted_key expected %0d got %0d", $time, e.rec.key, got.key);
        mismatches++;
      end
      if (got.tag !== e.rec.tag) begin
        $display("%0t: sorted_tag expected %h got %h", $time, e.rec.tag, got.tag);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: final_result expected %b got %b", $time, e.last, last);
        mismatches++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflowed expected %b got %b", $time, e.ovf, ovf);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rxsort_in_if  rec_in_ch ();
  rxsort_out_if rec_out_ch ();

  record_exchange_sort_by_key dut (
    .clk     (clk),
    .rst     (rst),
    .rec_in  (rec_in_ch),
    .rec_out (rec_out_ch)
  );

  sort_scoreboard board = new();

  int unsigned items_sent    = 0;
  int unsigned idle_odds     = 0;
  int unsigned cycle_count   = 0;
  bit          stall_request = 1'b0;

  always #2 clk = ~clk;

  // Signals only change just after a rising edge, so the falling edge sees
  // exactly what the next rising edge will transfer.
  always @(negedge clk) begin
    if (!rst && rec_out_ch.valid && rec_out_ch.ready)
      board.check_result('{key: rec_out_ch.sorted_key, tag: rec_out_ch.sorted_tag},
                         rec_out_ch.final_result, rec_out_ch.overflowed);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, board.pending());
    $display("[record_exchange_sort_by_key] ERROR");
    $finish;
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned burst_left;
    int unsigned stall_left;
    burst_left = 0;
    stall_left = 0;
    rec_out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left    = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        rec_out_ch.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        rec_out_ch.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
        burst_left = $urandom_range(0, 4);
        rec_out_ch.ready <= 1'b0;
      end else begin
        rec_out_ch.ready <= 1'b1;
      end
    end
  end

  // Called at a rising edge; returns at the rising edge that takes the record.
  task automatic send_record(input logic signed [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                             input logic closes);
    rec_t r;
    r = '{key: k, tag: t};
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      rec_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    rec_in_ch.valid      <= 1'b1;
    rec_in_ch.sort_key   <= k;
    rec_in_ch.record_tag <= t;
    rec_in_ch.batch_end  <= closes;
    do @(negedge clk); while (!rec_in_ch.ready);
    board.note_record(r, closes);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    rec_in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key(key_spread_e spread,
                                                       logic signed [KEY_W-1:0] base);
    case (spread)
      SPREAD_CLUSTER: return base + KEY_W'($urandom_range(0, 3));
      SPREAD_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          3:       return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      default: return KEY_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [KEY_W-1:0] dir_key [21];
    logic [TAG_W-1:0]        dir_tag [21];
    logic                    dir_end [21];
    logic signed [KEY_W-1:0] base;
    key_spread_e             spread;
    int unsigned             batch_no;
    int unsigned             size;
    int unsigned             roll;

    // Single record at the low extreme; mixed extremes; equal keys; reversed; in order.
    dir_key = '{16'sh8000,
                16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1,
                16'sd2024, 16'sd1999, 16'sd2024, 16'sd1999, 16'sd2024, -16'sd5,
                16'sd500, 16'sd400, 16'sd300, 16'sd200, 16'sd100,
                -16'sd3, -16'sd2, -16'sd1, 16'sd0};
    dir_tag = '{16'hFFFF,
                16'h0000, 16'hFFFF, 16'h1234, 16'h5555, 16'hAAAA,
                16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006,
                16'h00A0, 16'h00B0, 16'h00C0, 16'h00D0, 16'h00E0,
                16'hF000, 16'h0F00, 16'h00F0, 16'h000F};
    dir_end = '{1'b1,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b0, 1'b0, 1'b0, 1'b1};

    rst                  <= 1'b1;
    rec_in_ch.valid      <= 1'b0;
    rec_in_ch.sort_key   <= '0;
    rec_in_ch.record_tag <= '0;
    rec_in_ch.batch_end  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    idle_odds = 20;
    for (int n = 0; n < 21; n++) send_record(dir_key[n], dir_tag[n], dir_end[n]);
    wait_drained();

    batch_no = 0;
    while (items_sent < ITEMS) begin
      if (items_sent >= ITEMS - CALM_ITEMS)
        idle_odds = 0;
      else
        idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);

      // Hold the sink off so the close backs up the next batch at the input.
      if (batch_no == 1) stall_request = 1'b1;

      if (batch_no == 3) begin
        size = MAX_RECORDS;
      end else if (batch_no == 6) begin
        size = MAX_RECORDS + 1;
      end else if (batch_no == 10) begin
        size = MAX_RECORDS + $urandom_range(2, 6);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      size = $urandom_range(1, 8);
        else if (roll < 95) size = $urandom_range(9, 24);
        else                size = $urandom_range(25, 40);
      end

      base   = KEY_W'($urandom);
      spread = key_spread_e'($urandom_range(0, 2));
      for (int n = 0; n < size; n++)
        send_record(pick_key(spread, base), TAG_W'($urandom), n == size - 1);

      if (batch_no % 9 == 8) wait_drained();
      batch_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d records in %0d batches (%0d overflowing); checked %0d sorted results",
             items_sent, board.batches, board.overflow_batches, board.checked);
    $display("Covered single, full and overflowing batches, equal keys and a long sink stall");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[record_exchange_sort_by_key] OK");
    end else begin
      $display("[record_exchange_sort_by_key] ERROR");
    end
    $finish;
  end

endmodule
